[sv/kens_pkg.sv]
// ----------------------------------------------------------------------------
// kens_pkg
// Types and constants shared by the Newton-Raphson solver of the equation
// M = E - e*sin(E) and its arithmetic units.
// ----------------------------------------------------------------------------
package kens_pkg;

  // Q4.28 fixed point
  localparam int FRAC_W = 28;
  localparam logic signed [31:0] ONE     = 32'sd268435456;
  localparam logic signed [31:0] PI      = 32'sd843314857;
  localparam logic signed [31:0] HALF_PI = 32'sd421657428;
  localparam logic signed [31:0] TWO_PI  = 32'sd1686629713;
  localparam logic [33:0]        TWO_PI2 = 34'd3373259426;

  // serial divider widths: |f| << 28 over df
  localparam int DVD_W = 61;
  localparam int DVS_W = 29;
  localparam int DCNT_W = 6;

  // series steps: sine k = 8..1, then cosine k = 9..1
  localparam int HN = 17;
  localparam logic [4:0] H_SIN_LAST = 5'd7;
  localparam logic [4:0] H_COS_LAST = 5'd16;

  // register indexes on the configuration port
  localparam logic REG_ECC = 1'b0;
  localparam logic REG_TOL = 1'b1;

  // series divisor of one step
  function automatic logic [8:0] hdiv(input logic [4:0] idx);
    logic [8:0] d;
    unique case (idx)
      5'd0:  d = 9'd272;
      5'd1:  d = 9'd210;
      5'd2:  d = 9'd156;
      5'd3:  d = 9'd110;
      5'd4:  d = 9'd72;
      5'd5:  d = 9'd42;
      5'd6:  d = 9'd20;
      5'd7:  d = 9'd6;
      5'd8:  d = 9'd306;
      5'd9:  d = 9'd240;
      5'd10: d = 9'd182;
      5'd11: d = 9'd132;
      5'd12: d = 9'd90;
      5'd13: d = 9'd56;
      5'd14: d = 9'd30;
      5'd15: d = 9'd12;
      5'd16: d = 9'd2;
      default: d = 9'd1;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor) of one step
  function automatic logic [31:0] hrecip(input logic [4:0] idx);
    logic [31:0] r;
    unique case (idx)
      5'd0:  r = 32'd15790320;
      5'd1:  r = 32'd20452225;
      5'd2:  r = 32'd27531841;
      5'd3:  r = 32'd39045157;
      5'd4:  r = 32'd59652323;
      5'd5:  r = 32'd102261126;
      5'd6:  r = 32'd214748364;
      5'd7:  r = 32'd715827882;
      5'd8:  r = 32'd14035840;
      5'd9:  r = 32'd17895697;
      5'd10: r = 32'd23598721;
      5'd11: r = 32'd32537631;
      5'd12: r = 32'd47721858;
      5'd13: r = 32'd76695844;
      5'd14: r = 32'd143165576;
      5'd15: r = 32'd357913941;
      5'd16: r = 32'd2147483648;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // angle plus two turns, always positive
  function automatic logic [32:0] red_init(input logic signed [31:0] a);
    logic signed [33:0] s;
    s = 34'(a) + $signed(TWO_PI2);
    return s[32:0];
  endfunction

endpackage

[sv/kens_mul.sv]
// ----------------------------------------------------------------------------
// kens_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module kens_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod
);

  logic [63:0] prod_r;

  // register every product
  always_ff @(posedge clk) begin
    prod_r <= 64'(a) * 64'(b);
  end

  assign prod = prod_r;

endmodule

[sv/kens_div.sv]
// ----------------------------------------------------------------------------
// kens_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kens_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [kens_pkg::DVD_W-1:0]   dividend,
  input  logic [kens_pkg::DVS_W-1:0]   divisor,
  output logic                         done,
  output logic [kens_pkg::DVD_W-1:0]   quotient
);

  logic [kens_pkg::DVD_W-1:0]  quo_r;
  logic [kens_pkg::DVS_W-1:0]  rem_r;
  logic [kens_pkg::DVS_W-1:0]  dvs_r;
  logic [kens_pkg::DCNT_W-1:0] cnt_r;
  logic                        run_r;
  logic                        done_r;
  logic [kens_pkg::DVS_W:0]    shl;
  logic [kens_pkg::DVS_W:0]    diff;
  logic                        ge;

  // trial subtract of the shifted remainder
  always_comb begin
    shl  = {rem_r, quo_r[kens_pkg::DVD_W-1]};
    ge   = shl >= {1'b0, dvs_r};
    diff = shl - {1'b0, dvs_r};
  end

  // advance one bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r <= dividend;
        rem_r <= '0;
        dvs_r <= divisor;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        quo_r <= {quo_r[kens_pkg::DVD_W-2:0], ge};
        rem_r <= ge ? diff[kens_pkg::DVS_W-1:0] : shl[kens_pkg::DVS_W-1:0];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == kens_pkg::DCNT_W'(kens_pkg::DVD_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[sv/kepler_equation_newton_solver_unit.sv]
// ----------------------------------------------------------------------------
// kepler_equation_newton_solver_unit
// Newton-Raphson solver for E in M = E - e*sin(E), signed Q4.28 angles.
// ----------------------------------------------------------------------------
// Each Newton step runs the series sin/cos on the shared multiplier
//   (states HM1 to HM4 per term), then the serial divide; a word takes
//   from one to MAX_ITERATIONS Newton steps.
// Throughput: one word at a time; busy stays high until out_valid pulses.
// Reset: synchronous, active low; eccentricity clears to 0, tolerance to 1.
// The result is shown for one cycle and cannot be stalled.
module kepler_equation_newton_solver_unit #(
  parameter int MAX_ITERATIONS = 50
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  input  logic [30:0]        in_mean_anomaly,
  output logic               busy,
  output logic               out_valid,
  output logic signed [31:0] out_eccentric_anomaly,
  output logic               out_converged,
  output logic [5:0]         out_iterations_used
);

  localparam int IW = $clog2(MAX_ITERATIONS + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_RED, ST_FOLD, ST_SQ, ST_SQW, ST_HM1, ST_HM2, ST_HM3, ST_HM4,
    ST_SM, ST_E1, ST_E2, ST_DF, ST_DV
  } state_t;

  state_t             state_r;
  logic [27:0]        ecc_r;
  logic [20:0]        tol_r;
  logic [30:0]        m_r;
  logic signed [31:0] ea_r;
  logic [IW-1:0]      iter_r;
  logic [32:0]        red_r;
  logic [28:0]        r_mag_r;
  logic               r_neg_r;
  logic               cneg_r;
  logic [29:0]        x2_r;
  logic signed [31:0] t_r;
  logic signed [31:0] t_sin_r;
  logic [4:0]         hk_r;
  logic [29:0]        p_r;
  logic [29:0]        q0_r;
  logic               s_neg_r;
  logic               c_neg_r;
  logic signed [34:0] f_r;
  logic               out_valid_r;
  logic signed [31:0] out_ea_r;
  logic               out_conv_r;
  logic [5:0]         out_iter_r;

  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        mul_p;
  logic               div_start;
  logic [kens_pkg::DVD_W-1:0] div_dvd;
  logic [kens_pkg::DVS_W-1:0] div_dvs;
  logic               div_done;
  logic [kens_pkg::DVD_W-1:0] div_q;

  logic               cfg_wr;
  logic               accept;
  logic [28:0]        t_mag;
  logic signed [31:0] r_w;
  logic signed [31:0] r_f;
  logic               cn_w;
  logic [31:0]        rem_w;
  logic [29:0]        qh_w;
  logic signed [31:0] t_new;
  logic signed [34:0] es_x;
  logic signed [34:0] f_w;
  logic signed [30:0] ec_x;
  logic signed [30:0] df_w;
  logic [32:0]        f_mag;
  logic signed [62:0] dx_w;
  logic signed [62:0] ea_s;
  logic signed [31:0] ea_new;
  logic               conv_w;

  kens_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_p)
  );

  kens_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  assign cfg_wr = psel & penable & pwrite & pready;
  assign accept = start & ~busy;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == kens_pkg::REG_TOL) ? 32'(tol_r) : 32'(ecc_r);
  assign busy   = state_r != ST_IDLE;

  // angle reduction, series step and Newton update datapath
  always_comb begin
    t_mag = t_r[31] ? 29'(-t_r) : t_r[28:0];

    // fold into [-pi/2, pi/2]
    r_w  = $signed(32'(red_r));
    cn_w = 1'b0;
    if (r_w > kens_pkg::PI) r_w = r_w - kens_pkg::TWO_PI;
    if (r_w > kens_pkg::HALF_PI) begin
      r_f  = kens_pkg::PI - r_w;
      cn_w = 1'b1;
    end else if (r_w < -kens_pkg::HALF_PI) begin
      r_f  = -kens_pkg::PI - r_w;
      cn_w = 1'b1;
    end else begin
      r_f = r_w;
    end

    // correct the reciprocal quotient by one
    rem_w = 32'(p_r) - mul_p[31:0];
    qh_w  = (rem_w >= 32'(kens_pkg::hdiv(hk_r))) ? q0_r + 1'b1 : q0_r;
    t_new = t_r[31] ? kens_pkg::ONE + $signed({2'b00, qh_w})
                    : kens_pkg::ONE - $signed({2'b00, qh_w});

    // f = E - e*sin(E) - M
    es_x = $signed({5'b0, mul_p[57:28]});
    if (s_neg_r) es_x = -es_x;
    f_w  = 35'(ea_r) - es_x - $signed({4'b0, m_r});

    // df = 1 - e*cos(E), at least one lsb
    ec_x = $signed({1'b0, mul_p[57:28]});
    if (c_neg_r) ec_x = -ec_x;
    df_w = 31'(kens_pkg::ONE) - ec_x;
    f_mag = f_r[34] ? 33'(-f_r) : f_r[32:0];

    // Newton update with saturation
    dx_w   = $signed({2'b00, div_q});
    if (f_r[34]) dx_w = -dx_w;
    ea_s   = 63'(ea_r) - dx_w;
    if (ea_s > 63'sd2147483647) ea_new = 32'sh7fffffff;
    else if (ea_s < -63'sd2147483648) ea_new = 32'sh80000000;
    else ea_new = ea_s[31:0];
    conv_w = div_q < kens_pkg::DVD_W'(tol_r);
  end

  // steer the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_SQ: begin
        mul_a = 32'(r_mag_r);
        mul_b = 32'(r_mag_r);
      end
      ST_HM1: begin
        mul_a = 32'(x2_r);
        mul_b = 32'(t_mag);
      end
      ST_HM2: begin
        mul_a = 32'(mul_p[57:28]);
        mul_b = kens_pkg::hrecip(hk_r);
      end
      ST_HM3: begin
        mul_a = 32'(mul_p[61:32]);
        mul_b = 32'(kens_pkg::hdiv(hk_r));
      end
      ST_SM: begin
        mul_a = 32'(r_mag_r);
        mul_b = t_sin_r[31] ? 32'(-t_sin_r) : 32'(t_sin_r);
      end
      ST_E1: begin
        mul_a = 32'(ecc_r);
        mul_b = 32'(mul_p[57:28]);
      end
      ST_E2: begin
        mul_a = 32'(ecc_r);
        mul_b = 32'(t_mag);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign div_start = state_r == ST_DF;
  assign div_dvd   = {f_mag, 28'b0};
  assign div_dvs   = (df_w < 31'sd1) ? kens_pkg::DVS_W'(1) : df_w[28:0];

  // sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ecc_r       <= '0;
      tol_r       <= 21'd1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_wr) begin
        if (paddr[2] == kens_pkg::REG_ECC) ecc_r <= pwdata[27:0];
        else tol_r <= pwdata[20:0];
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            m_r     <= in_mean_anomaly;
            ea_r    <= $signed({1'b0, in_mean_anomaly});
            red_r   <= kens_pkg::red_init($signed({1'b0, in_mean_anomaly}));
            iter_r  <= '0;
            state_r <= ST_RED;
          end
        end
        ST_RED: begin
          if (red_r >= 33'(kens_pkg::TWO_PI)) red_r <= red_r - 33'(kens_pkg::TWO_PI);
          else state_r <= ST_FOLD;
        end
        ST_FOLD: begin
          r_neg_r <= r_f[31];
          r_mag_r <= r_f[31] ? 29'(-r_f) : r_f[28:0];
          cneg_r  <= cn_w;
          state_r <= ST_SQ;
        end
        ST_SQ: state_r <= ST_SQW;
        ST_SQW: begin
          x2_r    <= mul_p[57:28];
          t_r     <= kens_pkg::ONE;
          hk_r    <= '0;
          state_r <= ST_HM1;
        end
        ST_HM1: state_r <= ST_HM2;
        ST_HM2: begin
          p_r     <= mul_p[57:28];
          state_r <= ST_HM3;
        end
        ST_HM3: begin
          q0_r    <= mul_p[61:32];
          state_r <= ST_HM4;
        end
        ST_HM4: begin
          hk_r <= hk_r + 1'b1;
          if (hk_r == kens_pkg::H_SIN_LAST) begin
            t_sin_r <= t_new;
            t_r     <= kens_pkg::ONE;
            state_r <= ST_HM1;
          end else if (hk_r == kens_pkg::H_COS_LAST) begin
            t_r     <= t_new;
            state_r <= ST_SM;
          end else begin
            t_r     <= t_new;
            state_r <= ST_HM1;
          end
        end
        ST_SM: state_r <= ST_E1;
        ST_E1: begin
          s_neg_r <= t_sin_r[31] ^ r_neg_r;
          state_r <= ST_E2;
        end
        ST_E2: begin
          f_r     <= f_w;
          c_neg_r <= cneg_r ^ t_r[31];
          state_r <= ST_DF;
        end
        ST_DF: state_r <= ST_DV;
        ST_DV: begin
          if (div_done) begin
            ea_r   <= ea_new;
            iter_r <= iter_r + 1'b1;
            if (conv_w || iter_r == IW'(MAX_ITERATIONS - 1)) begin
              out_valid_r <= 1'b1;
              out_ea_r    <= ea_new;
              out_conv_r  <= conv_w;
              out_iter_r  <= 6'(iter_r + 1'b1);
              state_r     <= ST_IDLE;
            end else begin
              red_r   <= kens_pkg::red_init(ea_new);
              state_r <= ST_RED;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid             = out_valid_r;
  assign out_eccentric_anomaly = out_ea_r;
  assign out_converged         = out_conv_r;
  assign out_iterations_used   = out_iter_r;

endmodule
